@@ hw/rtl/csa_pkg.sv @@
// Shared types and constants for the contiguous segment allocator.
// No dependencies; imported by contiguous_segment_allocator.
package csa_pkg;

    localparam int OWNER_W    = 8;
    localparam int AMOUNT_W   = 21;
    localparam int ADDR_OUT_W = 20;
    localparam int STATUS_W   = 3;

    localparam logic [AMOUNT_W-1:0] TOTAL_SIZE_RESET = 21'd1048576;

    typedef enum logic [1:0] {
        MODE_INIT    = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_COMPACT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        FIT_FIRST   = 2'd0,
        FIT_BEST    = 2'd1,
        FIT_WORST   = 2'd2,
        FIT_INVALID = 2'd3
    } fit_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_SIZE = 3'd1,
        ST_BAD_FIT  = 3'd2,
        ST_NO_HOLE  = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_BOOT,
        S_IDLE,
        S_REQ_SCAN,
        S_REQ_DEC,
        S_SHIFT_UP,
        S_WR_LO,
        S_WR_HI,
        S_REL_SCAN,
        S_REL_NEXT,
        S_SHIFT_DN,
        S_CMP_SCAN,
        S_CMP_END,
        S_RESP
    } state_t;

endpackage

@@ hw/rtl/contiguous_segment_allocator.sv @@
// Contiguous segment allocator: address-ordered segment table in one memory.
// Depends on csa_pkg.
//
// Usage: one operation beat enters on s_* (mode, owner_id, amount, fit) and
// exactly one result beat leaves on m_* (status, start_address). The table
// of segments lives in a single simple dual-port memory (one write and one
// registered read per cycle); each scan or copy walks one entry a cycle.
// Steps: request scans and decides, shifts the entries above the hole up on
// a split, then writes the grant and the leftover hole; release finds the
// owner, merges it with free neighbors and moves later entries down when
// neighbors merge; compact slides owned segments down and gathers the free
// bytes into one hole.
// The single memory read port limits every walk to one entry per cycle.
// One operation is in flight at a time; s_ready is high when idle.
// The result sits in an output register, so a new beat is taken while the
// previous result still waits; if the receiver stalls, the next operation
// finishes and then holds until the output register frees up.
// Reset: total_size returns to 1048576 and the first cycle after reset
// writes entry 0 as one free hole; s_ready rises the cycle after that.
// cfg_total_size may be written whenever the block is idle; it takes effect
// at the next init operation.
module contiguous_segment_allocator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [csa_pkg::AMOUNT_W-1:0]   cfg_total_size,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_mode,
    input  logic [csa_pkg::OWNER_W-1:0]    s_owner_id,
    input  logic [csa_pkg::AMOUNT_W-1:0]   s_amount,
    input  logic [1:0]                     s_fit,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [csa_pkg::STATUS_W-1:0]   m_status,
    output logic [csa_pkg::ADDR_OUT_W-1:0] m_start_address
);
    import csa_pkg::*;

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    // Sizes and starts reach 2^ADDR_BITS and must also hold any amount.
    localparam int SW = (ADDR_BITS + 1 > AMOUNT_W) ? ADDR_BITS + 1 : AMOUNT_W;
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_SEGMENTS);
    localparam logic [SW-1:0] MEM_LIMIT = SW'(1) << ADDR_BITS;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [SW-1:0]      start;
        logic [SW-1:0]      size;
    } seg_t;

    // Segment table memory. Copy reads and writes never overlap on one entry: every
    // copy writes an entry other than the one read in the same cycle.
    seg_t mem [MAX_SEGMENTS];
    seg_t rdata_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    seg_t          mem_wdata;
    logic [IW-1:0] mem_raddr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AMOUNT_W-1:0]   total_size_reg, total_size_next;
    logic [OWNER_W-1:0]    owner_reg, owner_next;
    logic [SW-1:0]         amount_reg, amount_next;
    fit_t                  fit_reg, fit_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [CW-1:0]         pidx_reg, pidx_next;
    logic                  found_reg, found_next;
    logic [CW-1:0]         hidx_reg, hidx_next;
    seg_t                  hold_reg, hold_next;
    seg_t                  prev_reg, prev_next;
    logic                  prevfree_reg, prevfree_next;
    logic [CW-1:0]         src_reg, src_next;
    logic [CW-1:0]         dst_reg, dst_next;
    logic [1:0]            rm_reg, rm_next;
    logic [SW-1:0]         base_reg, base_next;
    logic [SW-1:0]         free_reg, free_next;
    status_t               res_status_reg, res_status_next;
    logic [ADDR_OUT_W-1:0] res_addr_reg, res_addr_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [ADDR_OUT_W-1:0] m_addr_reg, m_addr_next;

    logic          accept;
    logic [SW-1:0] init_size;
    logic          issue;
    logic          cand;
    logic          take;
    logic          next_free;
    logic [CW-1:0] w_idx;
    logic [SW-1:0] msize;
    logic [CW-1:0] src_calc;

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == S_IDLE);
    assign accept          = s_valid && s_ready;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_start_address = m_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_BOOT;
            count_reg      <= CW'(1);
            total_size_reg <= TOTAL_SIZE_RESET;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            total_size_reg <= total_size_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            m_valid_reg    <= m_valid_next;
        end
        owner_reg      <= owner_next;
        amount_reg     <= amount_next;
        fit_reg        <= fit_next;
        idx_reg        <= idx_next;
        pidx_reg       <= pidx_next;
        hidx_reg       <= hidx_next;
        hold_reg       <= hold_next;
        prev_reg       <= prev_next;
        prevfree_reg   <= prevfree_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        rm_reg         <= rm_next;
        base_reg       <= base_next;
        free_reg       <= free_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_size_next = total_size_reg;
        owner_next      = owner_reg;
        amount_next     = amount_reg;
        fit_next        = fit_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        found_next      = found_reg;
        hidx_next       = hidx_reg;
        hold_next       = hold_reg;
        prev_next       = prev_reg;
        prevfree_next   = prevfree_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        rm_next         = rm_reg;
        base_next       = base_reg;
        free_next       = free_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = idx_reg[IW-1:0];
        issue     = 1'b0;
        cand      = 1'b0;
        take      = 1'b0;
        next_free = 1'b0;
        w_idx     = hidx_reg;
        msize     = '0;
        src_calc  = '0;

        // Init clamps the configured size into 1 .. 2^ADDR_BITS.
        init_size = SW'(total_size_reg);
        if (total_size_reg == '0) begin
            init_size = SW'(1);
        end else if (SW'(total_size_reg) > MEM_LIMIT) begin
            init_size = MEM_LIMIT;
        end

        if (cfg_valid) begin
            total_size_next = cfg_total_size;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_BOOT: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = '{owner: '0, start: '0, size: init_size};
                count_next = CW'(1);
                state_next = S_IDLE;
            end

            S_IDLE: begin
                if (accept) begin
                    owner_next      = s_owner_id;
                    amount_next     = SW'(s_amount);
                    fit_next        = fit_t'(s_fit);
                    idx_next        = '0;
                    found_next      = 1'b0;
                    dst_next        = '0;
                    base_next       = '0;
                    free_next       = '0;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    case (mode_t'(s_mode))
                        MODE_INIT: begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = '{owner: '0, start: '0, size: init_size};
                            count_next = CW'(1);
                            state_next = S_RESP;
                        end
                        MODE_REQUEST: begin
                            if (s_amount == '0) begin
                                res_status_next = ST_BAD_SIZE;
                                state_next      = S_RESP;
                            end else if (fit_t'(s_fit) == FIT_INVALID) begin
                                res_status_next = ST_BAD_FIT;
                                state_next      = S_RESP;
                            end else if (s_owner_id == '0) begin
                                res_status_next = ST_UNKNOWN;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_REQ_SCAN;
                            end
                        end
                        MODE_RELEASE: begin
                            if (s_owner_id == '0) begin
                                res_status_next = ST_UNKNOWN;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_REL_SCAN;
                            end
                        end
                        MODE_COMPACT: begin
                            state_next = S_CMP_SCAN;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_REQ_SCAN: begin
                issue     = (idx_reg < count_reg);
                pend_next = issue;
                pidx_next = idx_reg;
                if (issue) begin
                    idx_next = idx_reg + CW'(1);
                end
                if (pend_reg) begin
                    cand = (rdata_reg.owner == '0) && (rdata_reg.size >= amount_reg);
                    take = !found_reg
                        || (fit_reg == FIT_BEST && rdata_reg.size < hold_reg.size)
                        || (fit_reg == FIT_WORST && rdata_reg.size > hold_reg.size);
                    if (cand && take) begin
                        found_next = 1'b1;
                        hidx_next  = pidx_reg;
                        hold_next  = rdata_reg;
                    end
                end
                if (!issue && !pend_reg) begin
                    state_next = S_REQ_DEC;
                end
            end

            S_REQ_DEC: begin
                if (!found_reg) begin
                    res_status_next = ST_NO_HOLE;
                    state_next      = S_RESP;
                end else if (hold_reg.size == amount_reg) begin
                    // Exact fit: the hole changes owner and nothing moves.
                    mem_we        = 1'b1;
                    mem_waddr     = hidx_reg[IW-1:0];
                    mem_wdata     = '{owner: owner_reg, start: hold_reg.start,
                                      size: hold_reg.size};
                    res_addr_next = hold_reg.start[ADDR_OUT_W-1:0];
                    state_next    = S_RESP;
                end else if (count_reg >= MAX_CNT) begin
                    res_status_next = ST_FULL;
                    state_next      = S_RESP;
                end else begin
                    src_next   = count_reg - CW'(1);
                    state_next = S_SHIFT_UP;
                end
            end

            S_SHIFT_UP: begin
                // Move entries above the hole up by one, top entry first.
                issue     = (src_reg > hidx_reg);
                mem_raddr = src_reg[IW-1:0];
                pend_next = issue;
                pidx_next = src_reg;
                if (issue) begin
                    src_next = src_reg - CW'(1);
                end
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = IW'(pidx_reg + CW'(1));
                    mem_wdata = rdata_reg;
                end
                if (!issue && !pend_reg) begin
                    state_next = S_WR_LO;
                end
            end

            S_WR_LO: begin
                mem_we     = 1'b1;
                mem_waddr  = hidx_reg[IW-1:0];
                mem_wdata  = '{owner: owner_reg, start: hold_reg.start, size: amount_reg};
                state_next = S_WR_HI;
            end

            S_WR_HI: begin
                mem_we          = 1'b1;
                mem_waddr       = IW'(hidx_reg + CW'(1));
                mem_wdata       = '{owner: '0, start: hold_reg.start + amount_reg,
                                    size: hold_reg.size - amount_reg};
                count_next      = count_reg + CW'(1);
                res_addr_next   = hold_reg.start[ADDR_OUT_W-1:0];
                state_next      = S_RESP;
            end

            S_REL_SCAN: begin
                issue     = (idx_reg < count_reg);
                pend_next = issue;
                pidx_next = idx_reg;
                if (issue) begin
                    idx_next = idx_reg + CW'(1);
                end
                if (pend_reg && rdata_reg.owner == owner_reg) begin
                    // The read issued this cycle is the right-hand neighbor.
                    hidx_next     = pidx_reg;
                    hold_next     = rdata_reg;
                    prevfree_next = (pidx_reg != '0) && (prev_reg.owner == '0);
                    state_next    = S_REL_NEXT;
                end else begin
                    if (pend_reg) begin
                        prev_next = rdata_reg;
                    end
                    if (!issue && !pend_reg) begin
                        res_status_next = ST_UNKNOWN;
                        state_next      = S_RESP;
                    end
                end
            end

            S_REL_NEXT: begin
                next_free = pend_reg && (rdata_reg.owner == '0);
                w_idx     = prevfree_reg ? hidx_reg - CW'(1) : hidx_reg;
                msize     = hold_reg.size
                          + (prevfree_reg ? prev_reg.size : SW'(0))
                          + (next_free ? rdata_reg.size : SW'(0));
                src_calc  = hidx_reg + CW'(1) + CW'(next_free);
                mem_we    = 1'b1;
                mem_waddr = w_idx[IW-1:0];
                mem_wdata = '{owner: '0,
                              start: prevfree_reg ? prev_reg.start : hold_reg.start,
                              size: msize};
                dst_next  = w_idx + CW'(1);
                src_next  = src_calc;
                rm_next   = 2'(prevfree_reg) + 2'(next_free);
                if (!prevfree_reg && !next_free) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_SHIFT_DN;
                end
            end

            S_SHIFT_DN: begin
                // Close the gap left by merged entries, lowest entry first.
                issue     = (src_reg < count_reg);
                mem_raddr = src_reg[IW-1:0];
                pend_next = issue;
                if (issue) begin
                    src_next = src_reg + CW'(1);
                end
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg[IW-1:0];
                    mem_wdata = rdata_reg;
                    dst_next  = dst_reg + CW'(1);
                end
                if (!issue && !pend_reg) begin
                    count_next = count_reg - CW'(rm_reg);
                    state_next = S_RESP;
                end
            end

            S_CMP_SCAN: begin
                issue     = (idx_reg < count_reg);
                pend_next = issue;
                if (issue) begin
                    idx_next = idx_reg + CW'(1);
                end
                if (pend_reg) begin
                    if (rdata_reg.owner != '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = dst_reg[IW-1:0];
                        mem_wdata = '{owner: rdata_reg.owner, start: base_reg,
                                      size: rdata_reg.size};
                        dst_next  = dst_reg + CW'(1);
                        base_next = base_reg + rdata_reg.size;
                    end else begin
                        free_next = free_reg + rdata_reg.size;
                    end
                end
                if (!issue && !pend_reg) begin
                    state_next = S_CMP_END;
                end
            end

            S_CMP_END: begin
                count_next = dst_reg;
                if (free_reg != '0 && dst_reg < MAX_CNT) begin
                    mem_we     = 1'b1;
                    mem_waddr  = dst_reg[IW-1:0];
                    mem_wdata  = '{owner: '0, start: base_reg, size: free_reg};
                    count_next = dst_reg + CW'(1);
                end
                state_next = S_RESP;
            end

            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = (res_status_reg == ST_OK) ? res_addr_reg : '0;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The table never empties and never outgrows its memory.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_BOOT) |-> (count_reg != '0 && count_reg <= MAX_CNT))
        else $error("segment count out of range");

    // Failed operations never report an address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> (m_addr_reg == '0))
        else $error("nonzero address on failed result");

    // Closing the merge gap always copies downward.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT_DN) |-> (dst_reg < src_reg))
        else $error("merge copy does not move entries down");

    // An accepted beat always takes the block out of idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept) |=> (state_reg != S_IDLE))
        else $error("operation accepted without leaving idle");

endmodule

@@ tb/contiguous_segment_allocator_tb.sv @@
// Self-checking testbench for contiguous_segment_allocator.
// Depends on csa_pkg and the allocator RTL; it keeps its own segment table and
// checks every result beat against it, with random idling on both channels in the random phases.
module contiguous_segment_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csa_pkg::*;

    localparam int SEGS = 64;
    localparam int MEM_MAX = 1 << 20;

    // One operation beat and one result beat.
    typedef struct {
        mode_t mode;
        logic [OWNER_W-1:0] owner;
        logic [AMOUNT_W-1:0] amount;
        fit_t fit;
    } op_t;

    typedef struct {
        status_t status;
        logic [ADDR_OUT_W-1:0] addr;
    } res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [AMOUNT_W-1:0] cfg_total_size = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_mode = '0;
    logic [OWNER_W-1:0] s_owner_id = '0;
    logic [AMOUNT_W-1:0] s_amount = '0;
    logic [1:0] s_fit = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [ADDR_OUT_W-1:0] m_start_address;

    always #5 aclk = ~aclk;

    contiguous_segment_allocator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_total_size(cfg_total_size),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_owner_id(s_owner_id), .s_amount(s_amount), .s_fit(s_fit),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_start_address(m_start_address)
    );

    // Shadow copy of the segment table.
    logic [OWNER_W-1:0] tbl_owner [SEGS];
    int unsigned tbl_start [SEGS];
    int unsigned tbl_size [SEGS];
    int unsigned tbl_count;
    int unsigned mem_bytes;      // configured total_size (21 bits)

    op_t pending_ops[$];
    res_t expected_results[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int ops_sent = 0;
    int results_seen = 0;
    int grants = 0;
    int fulls = 0;

    function automatic void table_init();
        int unsigned sz;
        sz = mem_bytes;
        if (sz < 1) sz = 1;
        if (sz > MEM_MAX) sz = MEM_MAX;
        for (int k = 0; k < SEGS; k++) begin
            tbl_owner[k] = '0;
            tbl_start[k] = 0;
            tbl_size[k] = 0;
        end
        tbl_size[0] = sz;
        tbl_count = 1;
    endfunction

    function automatic void drop_entry(int unsigned idx);
        for (int unsigned k = idx; k + 1 < tbl_count; k++) begin
            tbl_owner[k] = tbl_owner[k+1];
            tbl_start[k] = tbl_start[k+1];
            tbl_size[k] = tbl_size[k+1];
        end
        tbl_count--;
    endfunction

    // Applies one operation to the shadow table and returns its result.
    function automatic res_t allocate_step(op_t op);
        res_t r;
        int unsigned h;
        int unsigned k;
        int unsigned w;
        int unsigned base;
        int unsigned free_bytes;
        r.status = ST_OK;
        r.addr = '0;
        case (op.mode)
            MODE_INIT: begin
                table_init();
            end
            MODE_REQUEST: begin
                if (op.amount == 0) r.status = ST_BAD_SIZE;
                else if (op.fit == FIT_INVALID) r.status = ST_BAD_FIT;
                else if (op.owner == 0) r.status = ST_UNKNOWN;
                else begin
                    h = tbl_count;
                    for (k = 0; k < tbl_count; k++) begin
                        if (tbl_owner[k] != 0 || tbl_size[k] < op.amount) continue;
                        if (h == tbl_count) begin
                            h = k;
                            if (op.fit == FIT_FIRST) break;
                        end else if (op.fit == FIT_BEST && tbl_size[k] < tbl_size[h]) begin
                            h = k;
                        end else if (op.fit == FIT_WORST && tbl_size[k] > tbl_size[h]) begin
                            h = k;
                        end
                    end
                    if (h >= tbl_count) r.status = ST_NO_HOLE;
                    else if (tbl_size[h] == op.amount) begin
                        tbl_owner[h] = op.owner;
                        r.addr = ADDR_OUT_W'(tbl_start[h]);
                    end else if (tbl_count >= SEGS) r.status = ST_FULL;
                    else begin
                        for (k = tbl_count; k > h; k--) begin
                            tbl_owner[k] = tbl_owner[k-1];
                            tbl_start[k] = tbl_start[k-1];
                            tbl_size[k] = tbl_size[k-1];
                        end
                        tbl_count++;
                        tbl_owner[h] = op.owner;
                        tbl_size[h] = op.amount;
                        tbl_start[h+1] = tbl_start[h] + op.amount;
                        tbl_size[h+1] -= op.amount;
                        r.addr = ADDR_OUT_W'(tbl_start[h]);
                    end
                end
            end
            MODE_RELEASE: begin
                k = tbl_count;
                if (op.owner != 0) begin
                    for (k = 0; k < tbl_count; k++)
                        if (tbl_owner[k] == op.owner) break;
                end
                if (k >= tbl_count) r.status = ST_UNKNOWN;
                else begin
                    tbl_owner[k] = '0;
                    if (k + 1 < tbl_count && tbl_owner[k+1] == 0) begin
                        tbl_size[k] += tbl_size[k+1];
                        drop_entry(k + 1);
                    end
                    if (k > 0 && tbl_owner[k-1] == 0) begin
                        tbl_size[k-1] += tbl_size[k];
                        drop_entry(k);
                    end
                end
            end
            default: begin
                // Compaction: owned segments slide down, free bytes become one hole.
                w = 0;
                base = 0;
                free_bytes = 0;
                for (k = 0; k < tbl_count; k++) begin
                    if (tbl_owner[k] == 0) free_bytes += tbl_size[k];
                    else begin
                        tbl_owner[w] = tbl_owner[k];
                        tbl_size[w] = tbl_size[k];
                        tbl_start[w] = base;
                        base += tbl_size[k];
                        w++;
                    end
                end
                if (free_bytes > 0 && w < SEGS) begin
                    tbl_owner[w] = '0;
                    tbl_start[w] = base;
                    tbl_size[w] = free_bytes;
                    w++;
                end
                tbl_count = w;
            end
        endcase
        if (r.status != ST_OK) r.addr = '0;
        return r;
    endfunction

    // Driver: takes beats from the pending queue and holds each until accepted.
    always @(posedge aclk) begin
        op_t op;
        logic load;
        if (aresetn) begin
            load = 1'b0;
            if (s_valid && s_ready) begin
                expected_results.push_back(allocate_step(pending_ops.pop_front()));
                ops_sent++;
                load = 1'b1;
            end else if (!s_valid) begin
                load = 1'b1;
            end
            if (load) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    op = pending_ops[0];
                    s_valid <= 1'b1;
                    s_mode <= op.mode;
                    s_owner_id <= op.owner;
                    s_amount <= op.amount;
                    s_fit <= op.fit;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compares each result beat with the oldest expectation.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat status=%0d addr=%0h",
                         $time, m_status, m_start_address);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (want.status == ST_OK && want.addr != 0) grants++;
                if (want.status == ST_FULL) fulls++;
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_status);
                    errors++;
                end
                if (m_start_address !== want.addr) begin
                    $display("%0t: start_address expected %0h actual %0h",
                             $time, want.addr, m_start_address);
                    errors++;
                end
            end
        end
    end

    function automatic op_t make_op(mode_t m, int o, int a, fit_t f);
        op_t op;
        op.mode = m;
        op.owner = OWNER_W'(o);
        op.amount = AMOUNT_W'(a);
        op.fit = f;
        return op;
    endfunction

    // Mostly well-formed traffic: requests sized to the memory, releases of
    // owners from a small live pool, an occasional compaction or init.
    function automatic op_t random_op(int unsigned span);
        int pick;
        int a;
        pick = $urandom_range(99);
        if ($urandom_range(15) == 0) a = $urandom_range(MEM_MAX);
        else a = $urandom_range(span / 8 + 1, 1);
        if (pick < 52)
            return make_op(MODE_REQUEST, $urandom_range(12, 1), a,
                           fit_t'(2'($urandom_range(2))));
        if (pick < 56)
            return make_op(MODE_REQUEST, $urandom_range(255), a,
                           fit_t'(2'($urandom_range(3))));
        if (pick < 88)
            return make_op(MODE_RELEASE, $urandom_range(13, 0), $urandom,
                           fit_t'(2'($urandom)));
        if (pick < 97)
            return make_op(MODE_COMPACT, $urandom, $urandom, fit_t'(2'($urandom)));
        return make_op(MODE_INIT, $urandom, $urandom, fit_t'(2'($urandom)));
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        // Every result has been seen here; the extra wait is margin before the next phase.
        repeat (2 * SEGS + 20) @(posedge aclk);
    endtask

    task automatic write_total_size(int unsigned value);
        cfg_valid <= 1'b1;
        cfg_total_size <= AMOUNT_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        mem_bytes = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int n, int idle, int stall, int unsigned span);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) pending_ops.push_back(random_op(span));
        wait_drained();
    endtask

    initial begin
        mem_bytes = TOTAL_SIZE_RESET;
        table_init();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every error path but table-full, each fit and exact fits.
        pending_ops.push_back(make_op(MODE_REQUEST, 1, 0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 1, 16, FIT_INVALID));
        pending_ops.push_back(make_op(MODE_REQUEST, 0, 16, FIT_BEST));
        pending_ops.push_back(make_op(MODE_REQUEST, 255, 21'h1FFFFF, FIT_WORST));
        pending_ops.push_back(make_op(MODE_REQUEST, 1, 100, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 2, 50, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 3, 200, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_RELEASE, 2, 0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 4, 40, FIT_BEST));
        pending_ops.push_back(make_op(MODE_REQUEST, 5, 10, FIT_WORST));
        pending_ops.push_back(make_op(MODE_REQUEST, 6, 10, FIT_BEST));
        pending_ops.push_back(make_op(MODE_RELEASE, 0, 0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_RELEASE, 77, 0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_RELEASE, 1, 0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_RELEASE, 3, 0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_COMPACT, 0, 0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_INIT, 0, 0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 255, MEM_MAX, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_COMPACT, 0, 0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_RELEASE, 255, 0, FIT_FIRST));
        wait_drained();

        // Zero size clamps to one byte; fill it and compact with no free bytes.
        write_total_size(0);
        pending_ops.push_back(make_op(MODE_INIT, 0, 0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 9, 1, FIT_WORST));
        pending_ops.push_back(make_op(MODE_COMPACT, 0, 0, FIT_FIRST));
        wait_drained();

        // Table full: small splits until all 64 entries are in use.
        write_total_size(1000);
        pending_ops.push_back(make_op(MODE_INIT, 0, 0, FIT_FIRST));
        for (int i = 0; i < 66; i++)
            pending_ops.push_back(make_op(MODE_REQUEST, (i % 255) + 1, 1, FIT_FIRST));
        wait_drained();

        // Random phases with the four idling profiles and several sizes.
        run_random(450, 0, 0, 1000);
        write_total_size(21'h1FFFFF);   // above the limit, clamps to full memory
        pending_ops.push_back(make_op(MODE_INIT, 0, 0, FIT_FIRST));
        run_random(450, 67, 0, MEM_MAX);
        write_total_size(300);
        pending_ops.push_back(make_op(MODE_INIT, 0, 0, FIT_FIRST));
        run_random(450, 0, 67, 300);
        write_total_size(MEM_MAX);
        pending_ops.push_back(make_op(MODE_INIT, 0, 0, FIT_FIRST));
        run_random(450, 36, 36, 4096);

        $display("Ran %0d operations, %0d results checked (%0d nonzero grants, %0d table-full).",
                 ops_sent, results_seen, grants, fulls);
        $display("Covered all modes and fits, size clamping and four idling profiles.");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
